>>> rtl/core/tsm_pkg.sv
// Shared constants and widths for the timing synchronization metric block.
`default_nettype none

package tsm_pkg;

  // Depth of the energy delay line, in samples.
  localparam int WINDOW_LEN = 16;
  localparam int PTR_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // Field widths.
  localparam int CORR_W   = 16;
  localparam int ENERGY_W = 32;
  localparam int NUM_W    = 32;
  localparam int DEN_W    = 32;
  localparam int METRIC_W = 31;
  localparam int PROD_W   = 2 * ENERGY_W;

  // The metric is numerator * 2^METRIC_SHIFT / denominator.
  localparam int METRIC_SHIFT = 10;

  // One quotient bit is resolved per divider stage.
  localparam int DIV_STAGES = METRIC_W;

  // Right shift that leaves only the numerator bits that sit above the quotient range once scaled.
  localparam int OVF_SHIFT = METRIC_W - METRIC_SHIFT;

  localparam logic [METRIC_W-1:0] METRIC_MAX = {METRIC_W{1'b1}};

endpackage

`default_nettype wire

>>> rtl/core/tsm_in_if.sv
// Input channel of the timing synchronization metric block.
`default_nettype none

interface tsm_in_if
  import tsm_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [CORR_W-1:0]   corr_real;
  logic signed [CORR_W-1:0]   corr_imag;
  logic        [ENERGY_W-1:0] energy;

  modport source (output valid, output corr_real, output corr_imag, output energy,
                  input ready);
  modport sink   (input valid, input corr_real, input corr_imag, input energy,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/tsm_out_if.sv
// Result channel of the timing synchronization metric block.
`default_nettype none

interface tsm_out_if
  import tsm_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [NUM_W-1:0]    numerator;
  logic [DEN_W-1:0]    denominator;
  logic [METRIC_W-1:0] metric;

  modport source (output valid, output numerator, output denominator, output metric,
                  input ready);
  modport sink   (input valid, input numerator, input denominator, input metric,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/timing_sync_metric_top.sv
// Top level of the timing synchronization metric: delay line, products and divider.
`default_nettype none

// Computes one timing metric per input transaction: the squared magnitude of the
// complex correlation (numerator), the high word of the current energy times the
// energy of WINDOW_LEN transactions earlier plus one (denominator), and the exact
// truncated quotient numerator*1024/denominator saturated to 2^31-1 (metric). The
// block accepts one transaction every cycle unless the result consumer stalls. The
// result passes through a 31-stage restoring divider that resolves one quotient bit
// per stage. Ahead of it sit a multiply stage, a sum stage and a seed stage that
// checks for overflow. The input capture, which runs alongside the delay-line read,
// happens at the accepting edge itself. The output register follows the divider.
// The delayed energies live in a small synchronous memory
// that is read and written at the same address in the same cycle (read-first), so
// back-to-back transactions never conflict. Per-entry fill bits make the delay line
// read as zero after reset, with no clearing pass. When the result consumer stalls,
// the whole pipeline holds and input ready drops in the same cycle.
module timing_sync_metric_top
  import tsm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  tsm_in_if.sink     in_ch,
  tsm_out_if.source  out_ch
);

  logic advance;
  logic in_fire;

  // The pipeline moves as one; it stalls only when the output register is full
  // and not being taken.
  assign advance     = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;
  assign in_fire     = in_ch.valid && advance;

  // ---------------------------------------------------------------------------
  // Energy delay line: read-first memory plus per-entry fill bits.
  // ---------------------------------------------------------------------------
  logic [ENERGY_W-1:0]   dly_mem [0:WINDOW_LEN-1];
  logic [WINDOW_LEN-1:0] filled_r;
  logic [PTR_W-1:0]      ptr_r;
  logic [PTR_W-1:0]      ptr_nxt;
  logic [ENERGY_W-1:0]   rd_r;
  logic                  rd_ok_r;

  assign ptr_nxt = (ptr_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_r + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_r           <= dly_mem[ptr_r];
      dly_mem[ptr_r] <= in_ch.energy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      ptr_r    <= '0;
      rd_ok_r  <= 1'b0;
    end else if (in_fire) begin
      rd_ok_r         <= filled_r[ptr_r];
      filled_r[ptr_r] <= 1'b1;
      ptr_r           <= ptr_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: captured transaction, alongside the delay-line read.
  // ---------------------------------------------------------------------------
  logic                     s0_valid_r;
  logic signed [CORR_W-1:0] s0_re_r;
  logic signed [CORR_W-1:0] s0_im_r;
  logic [ENERGY_W-1:0]      s0_cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (advance) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_re_r  <= in_ch.corr_real;
      s0_im_r  <= in_ch.corr_imag;
      s0_cur_r <= in_ch.energy;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: squares and the energy product.
  // ---------------------------------------------------------------------------
  logic                        s1_valid_r;
  logic [NUM_W-1:0]            s1_sq_re_r;
  logic [NUM_W-1:0]            s1_sq_im_r;
  logic [PROD_W-1:0]           s1_prod_r;
  logic signed [2*CORR_W-1:0]  sq_re;
  logic signed [2*CORR_W-1:0]  sq_im;
  logic [ENERGY_W-1:0]         old_energy;

  assign sq_re      = s0_re_r * s0_re_r;
  assign sq_im      = s0_im_r * s0_im_r;
  assign old_energy = rd_ok_r ? rd_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sq_re_r <= NUM_W'($unsigned(sq_re));
      s1_sq_im_r <= NUM_W'($unsigned(sq_im));
      s1_prod_r  <= PROD_W'(s0_cur_r) * PROD_W'(old_energy);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: numerator and denominator. Both fit without wrapping: the sum of
  // squares is at most 2^31 and the high product word is at most 2^32-2.
  // ---------------------------------------------------------------------------
  logic             s2_valid_r;
  logic [NUM_W-1:0] s2_num_r;
  logic [DEN_W-1:0] s2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_num_r <= s1_sq_re_r + s1_sq_im_r;
      s2_den_r <= s1_prod_r[PROD_W-1 -: DEN_W] + DEN_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Divider. The scaled dividend is {numerator, 10 zero bits}. Its bits above
  // the quotient range seed the partial remainder; when they already reach the
  // denominator the quotient would not fit and the metric saturates. Otherwise
  // each stage shifts in one dividend bit and makes one compare-and-subtract.
  // ---------------------------------------------------------------------------
  logic                  dv_valid_r [0:DIV_STAGES];
  logic                  dv_ovf_r   [0:DIV_STAGES];
  logic [DEN_W-1:0]      dv_rem_r   [0:DIV_STAGES];
  logic [METRIC_W-1:0]   dv_low_r   [0:DIV_STAGES];
  logic [METRIC_W-1:0]   dv_q_r     [0:DIV_STAGES];
  logic [NUM_W-1:0]      dv_num_r   [0:DIV_STAGES];
  logic [DEN_W-1:0]      dv_den_r   [0:DIV_STAGES];
  logic [DEN_W-1:0]      seed_rem;

  assign seed_rem = DEN_W'(s2_num_r >> OVF_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (advance) begin
      dv_valid_r[0] <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dv_ovf_r[0] <= (seed_rem >= s2_den_r);
      dv_rem_r[0] <= seed_rem;
      dv_low_r[0] <= {s2_num_r[OVF_SHIFT-1:0], METRIC_SHIFT'(0)};
      dv_q_r[0]   <= '0;
      dv_num_r[0] <= s2_num_r;
      dv_den_r[0] <= s2_den_r;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {dv_rem_r[k], dv_low_r[k][METRIC_W-1]};
    assign diff  = trial - {1'b0, dv_den_r[k]};
    assign take  = (trial >= {1'b0, dv_den_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k+1] <= 1'b0;
      end else if (advance) begin
        dv_valid_r[k+1] <= dv_valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dv_ovf_r[k+1] <= dv_ovf_r[k];
        dv_rem_r[k+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        dv_low_r[k+1] <= {dv_low_r[k][METRIC_W-2:0], 1'b0};
        dv_q_r[k+1]   <= {dv_q_r[k][METRIC_W-2:0], take};
        dv_num_r[k+1] <= dv_num_r[k];
        dv_den_r[k+1] <= dv_den_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic                out_valid_r;
  logic [NUM_W-1:0]    out_num_r;
  logic [DEN_W-1:0]    out_den_r;
  logic [METRIC_W-1:0] out_metric_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= dv_valid_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_num_r    <= dv_num_r[DIV_STAGES];
      out_den_r    <= dv_den_r[DIV_STAGES];
      out_metric_r <= dv_ovf_r[DIV_STAGES] ? METRIC_MAX : dv_q_r[DIV_STAGES];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.numerator   = out_num_r;
  assign out_ch.denominator = out_den_r;
  assign out_ch.metric      = out_metric_r;

endmodule

`default_nettype wire
